// File: rtl/core/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg: shared types and constants of the reply frame checker
// Frame CRC constants, register and status codes, and the byte-wide
// CRC-16/MODBUS update used by the frame state logic.
// ----------------------------------------------------------------------------
package mrfc_pkg;

	// CRC-16/MODBUS, reflected
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// byte counter saturates here
	localparam logic [6:0] COUNT_TOP = 7'd127;

	// low 15 bits all ones marks a saturated reading
	localparam logic [14:0] SAT_MASK = 15'h7FFF;

	// default upper bound of a frame
	localparam int MAX_REPLY_BYTES_DEF = 64;

	// register reset values
	localparam logic [6:0] RST_REPLY_LENGTH    = 7'd7;
	localparam logic [7:0] RST_ECHO_FIRST      = 8'd254;
	localparam logic [7:0] RST_ECHO_SECOND     = 8'd4;
	localparam logic [5:0] RST_VALUE_POSITION  = 6'd3;
	localparam logic [2:0] RST_VALUE_SIZE      = 3'd2;
	localparam logic       RST_CHECK_SATURATED = 1'b1;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_REPLY_LENGTH     = 3'd0,
		CFG_ECHO_FIRST_BYTE  = 3'd1,
		CFG_ECHO_SECOND_BYTE = 3'd2,
		CFG_VALUE_POSITION   = 3'd3,
		CFG_VALUE_SIZE       = 3'd4,
		CFG_CHECK_SATURATED  = 3'd5
	} cfg_idx_t;

	// item kind
	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	// result status, in priority order
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_LENGTH    = 3'd1,
		STAT_ECHO      = 3'd2,
		STAT_CRC       = 3'd3,
		STAT_SATURATED = 3'd4
	} status_t;

	typedef struct packed {
		logic [6:0] reply_length;
		logic [7:0] echo_first_byte;
		logic [7:0] echo_second_byte;
		logic [5:0] value_position;
		logic [2:0] value_size;
		logic       check_saturated;
	} cfg_t;

	// item held in the input register
	typedef struct packed {
		logic       valid;
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] value;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	// one byte into the running CRC, eight shift steps
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/core/mrfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrfc_cfg_regs: configuration registers
// Write-only register file, one register per index, reset to defaults.
// ----------------------------------------------------------------------------
module mrfc_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [2:0]      cfg_index,
	input  logic [7:0]      cfg_wdata,
	output mrfc_pkg::cfg_t  cfg
);

	mrfc_pkg::cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reply_length     <= mrfc_pkg::RST_REPLY_LENGTH;
			cfg_q.echo_first_byte  <= mrfc_pkg::RST_ECHO_FIRST;
			cfg_q.echo_second_byte <= mrfc_pkg::RST_ECHO_SECOND;
			cfg_q.value_position   <= mrfc_pkg::RST_VALUE_POSITION;
			cfg_q.value_size       <= mrfc_pkg::RST_VALUE_SIZE;
			cfg_q.check_saturated  <= mrfc_pkg::RST_CHECK_SATURATED;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mrfc_pkg::CFG_REPLY_LENGTH:     cfg_q.reply_length     <= cfg_wdata[6:0];
				mrfc_pkg::CFG_ECHO_FIRST_BYTE:  cfg_q.echo_first_byte  <= cfg_wdata;
				mrfc_pkg::CFG_ECHO_SECOND_BYTE: cfg_q.echo_second_byte <= cfg_wdata;
				mrfc_pkg::CFG_VALUE_POSITION:   cfg_q.value_position   <= cfg_wdata[5:0];
				mrfc_pkg::CFG_VALUE_SIZE:       cfg_q.value_size       <= cfg_wdata[2:0];
				mrfc_pkg::CFG_CHECK_SATURATED:  cfg_q.check_saturated  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mrfc_in_stage.sv
// ----------------------------------------------------------------------------
// mrfc_in_stage: input register
// Captures one item per cycle; holds an end item only while the result
// register is full and stalled.
// ----------------------------------------------------------------------------
module mrfc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            kind,
	input  logic [7:0]      data_byte,
	input  logic            out_busy,
	output mrfc_pkg::item_t item_s1,
	output logic            take_s1
);

	logic              valid_q_s1;
	mrfc_pkg::kind_t   kind_q_s1;
	logic [7:0]        data_q_s1;

	// a byte always moves on; an end item needs room in the result register
	assign take_s1  = valid_q_s1 &&
	                  ((kind_q_s1 == mrfc_pkg::KIND_BYTE) || !out_busy);
	assign in_stall = valid_q_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_q_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_q_s1 <= mrfc_pkg::kind_t'(kind);
			data_q_s1 <= data_byte;
		end
	end

	assign item_s1 = '{valid: valid_q_s1, kind: kind_q_s1, data: data_q_s1};

	// stall only ever comes from a waiting end item behind a full result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_q_s1 && kind_q_s1 == mrfc_pkg::KIND_END && out_busy))
		else $error("input stalled without a blocked end item");

	// a held item stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_q_s1 && $stable(kind_q_s1)))
		else $error("stalled item lost");

endmodule

// File: rtl/core/mrfc_frame.sv
// ----------------------------------------------------------------------------
// mrfc_frame: frame state and verdict
// Running CRC over the body, two-byte hold-back, echo check, value gather,
// and the status decision on an end item.
// ----------------------------------------------------------------------------
module mrfc_frame #(
	parameter int MAX_REPLY_BYTES = mrfc_pkg::MAX_REPLY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mrfc_pkg::cfg_t    cfg,
	input  mrfc_pkg::item_t   item_s1,
	input  logic              take_s1,
	output logic              res_load,
	output mrfc_pkg::result_t res
);

	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [15:0] crc_q;
	logic [6:0]  count_q;
	logic        echo_bad_q;
	logic [31:0] acc_q;

	logic        byte_take;
	logic [15:0] crc_next;
	logic        echo_miss;
	logic        in_window;
	logic [7:0]  window_end;
	logic        len_bad;
	logic [15:0] rx_crc;

	assign byte_take = take_s1 && (item_s1.kind == mrfc_pkg::KIND_BYTE);
	assign res_load  = take_s1 && (item_s1.kind == mrfc_pkg::KIND_END);

	// body CRC: the byte leaving the hold-back pair is fed
	assign crc_next = (count_q >= 7'd2) ? mrfc_pkg::crc_feed(crc_q, held0_q) : crc_q;

	// address and function code echo
	assign echo_miss = ((count_q == 7'd0) && (item_s1.data != cfg.echo_first_byte)) ||
	                   ((count_q == 7'd1) && (item_s1.data != cfg.echo_second_byte));

	// value byte window
	assign window_end = {2'b00, cfg.value_position} + {5'b00000, cfg.value_size};
	assign in_window  = (cfg.value_size != 3'd0) &&
	                    ({1'b0, count_q} >= {2'b00, cfg.value_position}) &&
	                    ({1'b0, count_q} < window_end);

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			crc_q      <= mrfc_pkg::CRC_INIT;
			count_q    <= 7'd0;
			echo_bad_q <= 1'b0;
			acc_q      <= 32'd0;
		end else if (res_load) begin
			held0_q    <= 8'h00;
			held1_q    <= 8'h00;
			crc_q      <= mrfc_pkg::CRC_INIT;
			count_q    <= 7'd0;
			echo_bad_q <= 1'b0;
			acc_q      <= 32'd0;
		end else if (byte_take) begin
			held0_q <= held1_q;
			held1_q <= item_s1.data;
			crc_q   <= crc_next;
			if (echo_miss) begin
				echo_bad_q <= 1'b1;
			end
			if (in_window) begin
				acc_q <= {acc_q[23:0], item_s1.data};
			end
			if (count_q < mrfc_pkg::COUNT_TOP) begin
				count_q <= count_q + 7'd1;
			end
		end
	end

	// verdict
	assign rx_crc  = {held1_q, held0_q};
	assign len_bad = (count_q < 7'd2) || (count_q == mrfc_pkg::COUNT_TOP) ||
	                 (count_q != cfg.reply_length) ||
	                 (32'(cfg.reply_length) > 32'(MAX_REPLY_BYTES));

	always_comb begin
		if (len_bad) begin
			res.status = mrfc_pkg::STAT_LENGTH;
		end else if (echo_bad_q) begin
			res.status = mrfc_pkg::STAT_ECHO;
		end else if (crc_q != rx_crc) begin
			res.status = mrfc_pkg::STAT_CRC;
		end else if (cfg.check_saturated && (acc_q[14:0] == mrfc_pkg::SAT_MASK)) begin
			res.status = mrfc_pkg::STAT_SATURATED;
		end else begin
			res.status = mrfc_pkg::STAT_OK;
		end
		res.value        = acc_q;
		res.received_crc = rx_crc;
		res.computed_crc = crc_q;
	end

	// every end item leaves a fresh frame behind
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (count_q == 7'd0 && crc_q == mrfc_pkg::CRC_INIT && !echo_bad_q))
		else $error("frame state not cleared after end item");

	// counter holds at its top until the frame ends
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == mrfc_pkg::COUNT_TOP && !res_load) |=> (count_q == mrfc_pkg::COUNT_TOP))
		else $error("byte counter wrapped");

endmodule

// File: rtl/core/mrfc_out_stage.sv
// ----------------------------------------------------------------------------
// mrfc_out_stage: result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module mrfc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  mrfc_pkg::result_t res,
	output logic              out_busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [2:0]        status,
	output logic [31:0]       value,
	output logic [15:0]       received_crc,
	output logic [15:0]       computed_crc
);

	logic              valid_q;
	mrfc_pkg::result_t res_q;

	assign out_busy = valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid    = valid_q;
	assign status       = res_q.status;
	assign value        = res_q.value;
	assign received_crc = res_q.received_crc;
	assign computed_crc = res_q.computed_crc;

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(valid_q && out_stall))
		else $error("result overwritten while stalled");

endmodule

// File: rtl/core/modbus_reply_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_reply_frame_checker: Modbus RTU reply frame checker
// Checks a reply one byte per item against CRC-16/MODBUS, length and echo,
// gathers a big-endian value and gives one result per end-of-reply item.
//
//   channel  direction  handshake            payload
//   in       into       in_valid / in_stall  kind, data_byte
//   out      out of     out_valid/out_stall  status, value, received_crc,
//                                            computed_crc
//   cfg      into       cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle unless in_stall holds it: each item is held in the input
// register, where the byte-wide CRC update and the verdict logic act on it.
// A result is registered in the result register, which drives out.
// Byte items never stall; an end item waits only while the result register
// is full and stalled.
// Reset clears the frame state and loads the register defaults.
// ----------------------------------------------------------------------------
module modbus_reply_frame_checker #(
	parameter int MAX_REPLY_BYTES = mrfc_pkg::MAX_REPLY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] value,
	output logic [15:0] received_crc,
	output logic [15:0] computed_crc
);

	mrfc_pkg::cfg_t    cfg;
	mrfc_pkg::item_t   item_s1;
	mrfc_pkg::result_t res;
	logic              take_s1;
	logic              res_load;
	logic              out_busy;

	mrfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mrfc_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.out_busy  (out_busy),
		.item_s1   (item_s1),
		.take_s1   (take_s1)
	);

	mrfc_frame #(
		.MAX_REPLY_BYTES (MAX_REPLY_BYTES)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.item_s1  (item_s1),
		.take_s1  (take_s1),
		.res_load (res_load),
		.res      (res)
	);

	mrfc_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res          (res),
		.out_busy     (out_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.value        (value),
		.received_crc (received_crc),
		.computed_crc (computed_crc)
	);

endmodule

// File: dv/modbus_reply_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// modbus_reply_frame_checker_tb: self-checking bench of the reply frame checker
// Sends reply frames byte by byte with random gaps and output stalls, predicts
// each verdict (status, value, received and computed CRC) in a scoreboard and
// compares every result item against it. Frames are mostly well formed, with
// echo, CRC, length and saturation faults and raw noise mixed in, under a
// series of register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_reply_frame_checker_tb;

	localparam int CYCLE_LIMIT = 100000;

	typedef bit [7:0] byte_q_t[$];

	// shapes of generated frames
	typedef enum {
		FR_GOOD,
		FR_ECHO,
		FR_CRC,
		FR_LEN,
		FR_SAT,
		FR_NOISE
	} frame_shape_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_wr_en    = 1'b0;
	logic [2:0]  cfg_index    = '0;
	logic [7:0]  cfg_wdata    = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic        kind         = 1'b0;
	logic [7:0]  data_byte    = '0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic [2:0]  status;
	logic [31:0] value;
	logic [15:0] received_crc;
	logic [15:0] computed_crc;

	// no idling on either side while set
	bit calm = 1'b0;
	int items_sent = 0;
	int cycles = 0;

	modbus_reply_frame_checker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.value        (value),
		.received_crc (received_crc),
		.computed_crc (computed_crc)
	);

	// Verdict predictor and store of verdicts still due
	class reply_verdicts;
		bit [6:0]  len;
		bit [7:0]  echo0;
		bit [7:0]  echo1;
		bit [5:0]  pos;
		bit [2:0]  size;
		bit        sat_on;

		bit [7:0]  held[2];
		bit [15:0] crc;
		bit [6:0]  count;
		bit        echo_bad;
		bit [31:0] acc;

		mrfc_pkg::result_t verdicts_due[$];
		int                mismatches;

		function new();
			len        = mrfc_pkg::RST_REPLY_LENGTH;
			echo0      = mrfc_pkg::RST_ECHO_FIRST;
			echo1      = mrfc_pkg::RST_ECHO_SECOND;
			pos        = mrfc_pkg::RST_VALUE_POSITION;
			size       = mrfc_pkg::RST_VALUE_SIZE;
			sat_on     = mrfc_pkg::RST_CHECK_SATURATED;
			mismatches = 0;
			clear_frame();
		endfunction

		static function bit [15:0] crc_byte(bit [15:0] c, bit [7:0] b);
			bit [15:0] r;
			r = c ^ {8'h00, b};
			repeat (8) r = r[0] ? ((r >> 1) ^ mrfc_pkg::CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void clear_frame();
			held[0]  = '0;
			held[1]  = '0;
			crc      = mrfc_pkg::CRC_INIT;
			count    = '0;
			echo_bad = 1'b0;
			acc      = '0;
		endfunction

		// register writes keep only the register's width
		function void write_reg(mrfc_pkg::cfg_idx_t idx, bit [7:0] d);
			case (idx)
				mrfc_pkg::CFG_REPLY_LENGTH:     len    = d[6:0];
				mrfc_pkg::CFG_ECHO_FIRST_BYTE:  echo0  = d;
				mrfc_pkg::CFG_ECHO_SECOND_BYTE: echo1  = d;
				mrfc_pkg::CFG_VALUE_POSITION:   pos    = d[5:0];
				mrfc_pkg::CFG_VALUE_SIZE:       size   = d[2:0];
				mrfc_pkg::CFG_CHECK_SATURATED:  sat_on = d[0];
				default: ;
			endcase
		endfunction

		// advance the frame by one accepted item; an end item yields a verdict
		function void note_item(mrfc_pkg::kind_t k, bit [7:0] b);
			mrfc_pkg::result_t v;
			bit [15:0]         rx;
			if (k == mrfc_pkg::KIND_BYTE) begin
				// CRC trails two bytes behind, the held pair may be the CRC
				if (count >= 2) crc = crc_byte(crc, held[0]);
				held[0] = held[1];
				held[1] = b;
				if (count == 0 && b != echo0) echo_bad = 1'b1;
				if (count == 1 && b != echo1) echo_bad = 1'b1;
				if (size != 0 && int'(count) >= int'(pos) &&
						int'(count) < int'(pos) + int'(size))
					acc = {acc[23:0], b};
				if (count != mrfc_pkg::COUNT_TOP) count++;
				return;
			end
			rx = {held[1], held[0]};
			if (count < 2 || count == mrfc_pkg::COUNT_TOP || count != len ||
					int'(len) > mrfc_pkg::MAX_REPLY_BYTES_DEF)
				v.status = mrfc_pkg::STAT_LENGTH;
			else if (echo_bad)
				v.status = mrfc_pkg::STAT_ECHO;
			else if (crc != rx)
				v.status = mrfc_pkg::STAT_CRC;
			else if (sat_on && acc[14:0] == mrfc_pkg::SAT_MASK)
				v.status = mrfc_pkg::STAT_SATURATED;
			else
				v.status = mrfc_pkg::STAT_OK;
			v.value        = acc;
			v.received_crc = rx;
			v.computed_crc = crc;
			verdicts_due.push_back(v);
			clear_frame();
		endfunction

		function void check_verdict(mrfc_pkg::result_t got);
			mrfc_pkg::result_t want;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with none due: status %0d value %h rx %h crc %h",
						$realtime, got.status, got.value, got.received_crc, got.computed_crc);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.status != want.status || got.value != want.value ||
					got.received_crc != want.received_crc ||
					got.computed_crc != want.computed_crc) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: verdict mismatch: status %0d/%0d value %h/%h rx %h/%h crc %h/%h",
						$realtime, want.status, got.status, want.value, got.value,
						want.received_crc, got.received_crc, want.computed_crc, got.computed_crc);
			end
		endfunction
	endclass

	reply_verdicts board = new();

	// clock
	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side: check accepted items, stall at random
	always @(posedge clk) begin : collect_results
		mrfc_pkg::result_t got;
		if (out_valid && !out_stall) begin
			got.status       = mrfc_pkg::status_t'(status);
			got.value        = value;
			got.received_crc = received_crc;
			got.computed_crc = computed_crc;
			board.check_verdict(got);
		end
		out_stall <= !calm && ($urandom_range(99) < 30);
	end

	// one item on the input channel, with a random gap first
	task automatic send_item(mrfc_pkg::kind_t k, bit [7:0] b);
		while (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_item(k, b);
		items_sent++;
	endtask

	task automatic send_reply(byte_q_t q);
		foreach (q[i]) send_item(mrfc_pkg::KIND_BYTE, q[i]);
		send_item(mrfc_pkg::KIND_END, 8'($urandom));
	endtask

	// stop sending until every verdict is in and the pipe is empty
	task automatic settle();
		in_valid <= 1'b0;
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(mrfc_pkg::cfg_idx_t idx, bit [7:0] d);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(posedge clk);
		board.write_reg(idx, d);
	endtask

	// all six registers; junk puts random bits above the narrow ones
	task automatic apply_config(bit [6:0] len, bit [7:0] e0, bit [7:0] e1, bit [5:0] pos,
			bit [2:0] size, bit sat, bit junk);
		bit [7:0] noise;
		noise = junk ? 8'($urandom) : 8'h00;
		cfg_write(mrfc_pkg::CFG_REPLY_LENGTH, {noise[7], len});
		cfg_write(mrfc_pkg::CFG_ECHO_FIRST_BYTE, e0);
		cfg_write(mrfc_pkg::CFG_ECHO_SECOND_BYTE, e1);
		cfg_write(mrfc_pkg::CFG_VALUE_POSITION, {noise[7:6], pos});
		cfg_write(mrfc_pkg::CFG_VALUE_SIZE, {noise[7:3], size});
		cfg_write(mrfc_pkg::CFG_CHECK_SATURATED, {noise[7:1], sat});
		cfg_wr_en <= 1'b0;
	endtask

	function automatic byte_q_t with_crc(byte_q_t body);
		bit [15:0] c;
		c = mrfc_pkg::CRC_INIT;
		foreach (body[i]) c = reply_verdicts::crc_byte(c, body[i]);
		body.push_back(c[7:0]);
		body.push_back(c[15:8]);
		return body;
	endfunction

	// build a frame of total length n for the current settings, then fault it
	task automatic send_frame(frame_shape_t shape, int n);
		byte_q_t q;
		int p;
		int e;
		if (shape == FR_NOISE) begin
			repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
			send_reply(q);
			return;
		end
		repeat (n - 2) q.push_back(8'($urandom));
		if (q.size() > 0) q[0] = board.echo0;
		if (q.size() > 1) q[1] = board.echo1;
		if (shape == FR_ECHO && q.size() > 0) begin
			p = $urandom_range(0, q.size() > 1 ? 1 : 0);
			q[p] = q[p] ^ (8'h01 << $urandom_range(7));
		end
		// low 15 bits of the gathered value all ones
		e = int'(board.pos) + int'(board.size);
		if (shape == FR_SAT && board.size >= 2 && e <= q.size() && e - 2 >= 2) begin
			q[e - 1] = 8'hFF;
			q[e - 2] = q[e - 2] | 8'h7F;
		end
		q = with_crc(q);
		if (shape == FR_CRC) begin
			p = q.size() - 1 - $urandom_range(1);
			q[p] = q[p] ^ (8'h01 << $urandom_range(7));
		end
		if (shape == FR_LEN) begin
			if ($urandom_range(1) && q.size() > 1)
				repeat ($urandom_range(1, q.size() > 3 ? 3 : q.size() - 1)) void'(q.pop_back());
			else
				repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
		end
		send_reply(q);
	endtask

	function automatic frame_shape_t pick_shape();
		int r;
		r = $urandom_range(99);
		if (r < 50) return FR_GOOD;
		if (r < 60) return FR_ECHO;
		if (r < 70) return FR_CRC;
		if (r < 80) return FR_LEN;
		if (r < 90) return FR_SAT;
		return FR_NOISE;
	endfunction

	// random frames until the item budget is spent, draining now and then
	task automatic run_frames(int budget);
		int start;
		int n;
		start = items_sent;
		n = 0;
		while (items_sent - start < budget) begin
			if (board.len >= 2 && int'(board.len) <= mrfc_pkg::MAX_REPLY_BYTES_DEF)
				send_frame(pick_shape(), board.len);
			else
				send_frame(pick_shape(), $urandom_range(2, 20));
			n++;
			if (n % 5 == 4) settle();
		end
		settle();
	endtask

	// stimulus
	initial begin : stimulus
		byte_q_t q;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: a clean reply, a saturated reading, empty and one-byte replies
		q = '{8'hFE, 8'h04, 8'h00, 8'hFF, 8'h12};
		send_reply(with_crc(q));
		q = '{8'hFE, 8'h04, 8'h02, 8'h7F, 8'hFF};
		send_reply(with_crc(q));
		send_item(mrfc_pkg::KIND_END, 8'hFF);
		send_item(mrfc_pkg::KIND_BYTE, 8'hFE);
		send_item(mrfc_pkg::KIND_END, 8'h00);
		settle();

		// shortest frame: CRC bytes only, echo and value on them
		apply_config(7'd2, 8'hFF, 8'hFF, 6'd0, 3'd4, 1'b1, 1'b0);
		run_frames(40);

		// longest legal frame, value on the last byte, no idling anywhere
		calm = 1'b1;
		apply_config(7'd64, 8'($urandom), 8'($urandom), 6'd63, 3'd1, 1'b0, 1'b1);
		run_frames(100);
		calm = 1'b0;

		// length above the frame bound, oversized value field
		apply_config(7'd100, 8'($urandom), 8'($urandom), 6'd1, 3'd7, 1'b1, 1'b1);
		run_frames(50);

		// byte count runs into saturation
		apply_config(7'd127, 8'h00, 8'h00, 6'd0, 3'd0, 1'b1, 1'b0);
		send_frame(FR_GOOD, 130);
		run_frames(20);

		// random settings
		repeat (4) begin
			automatic bit [6:0] len = 7'($urandom_range(2, 24));
			apply_config(len, 8'($urandom), 8'($urandom), 6'($urandom_range(0, len)),
				3'($urandom_range(99) < 80 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
				1'($urandom), 1'($urandom));
			run_frames(30);
		end

		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.verdicts_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
